FILE: hdl/rip_pkg.sv
// shared types, constants and the digit decoder for the radix integer parser
`default_nettype none

package rip_pkg;

  localparam int VALUE_WIDTH_DEF = 64;
  localparam int MAG_WIDTH       = 64;
  localparam int CHAR_WIDTH      = 8;
  localparam int RADIX_WIDTH     = 6;

  localparam logic [RADIX_WIDTH-1:0] NOT_DIGIT     = 6'd36;
  localparam logic [RADIX_WIDTH-1:0] RADIX_DEFAULT = 6'd10;
  localparam logic [RADIX_WIDTH-1:0] RADIX_HEX     = 6'd16;
  localparam logic [RADIX_WIDTH-1:0] RADIX_MIN     = 6'd2;
  localparam logic [RADIX_WIDTH-1:0] RADIX_MAX     = 6'd32;

  localparam logic [CHAR_WIDTH-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_WIDTH-1:0] CH_CR     = 8'h0d;
  localparam logic [CHAR_WIDTH-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_WIDTH-1:0] CH_PLUS   = 8'h2b;
  localparam logic [CHAR_WIDTH-1:0] CH_MINUS  = 8'h2d;
  localparam logic [CHAR_WIDTH-1:0] CH_ZERO   = 8'h30;
  localparam logic [CHAR_WIDTH-1:0] CH_NINE   = 8'h39;
  localparam logic [CHAR_WIDTH-1:0] CH_UP_A   = 8'h41;
  localparam logic [CHAR_WIDTH-1:0] CH_UP_X   = 8'h58;
  localparam logic [CHAR_WIDTH-1:0] CH_UP_Z   = 8'h5a;
  localparam logic [CHAR_WIDTH-1:0] CH_LO_A   = 8'h61;
  localparam logic [CHAR_WIDTH-1:0] CH_LO_X   = 8'h78;
  localparam logic [CHAR_WIDTH-1:0] CH_LO_Z   = 8'h7a;

  typedef enum logic [2:0] {
    PH_START,
    PH_SPACE,
    PH_FIRST,
    PH_ZERO,
    PH_DIGITS,
    PH_STOPPED,
    PH_BAD
  } phase_t;

  function automatic logic [RADIX_WIDTH-1:0] digit_value(input logic [CHAR_WIDTH-1:0] c);
    logic [CHAR_WIDTH-1:0] t;
    t = '0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      t = c - CH_ZERO;
    end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
      t = c - CH_LO_A + 8'd10;
    end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
      t = c - CH_UP_A + 8'd10;
    end else begin
      t = {2'b00, NOT_DIGIT};
    end
    return t[RADIX_WIDTH-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: hdl/radix_integer_parser.sv
// streaming radix integer parser: at most one character per transaction, one result per string
//
//  channel  signals                                          direction
//  item     item_valid item_ready character char_valid       in
//           radix last
//  result   result_valid result_ready magnitude negative      out
//           not_a_number saturated
//
// one character is taken per cycle while the input register is not held; each waits in the
// input register and its multiply-add by the radix into the accumulator is done as it leaves
// a string's result is registered as its last character leaves the input register
// synchronous reset returns the parse state to the start of a string
// when the result register is full and not taken, a waiting last character holds
// the input register; other characters keep flowing
`default_nettype none

module radix_integer_parser
  import rip_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   item_valid,
  output logic                        item_ready,
  input  wire logic [CHAR_WIDTH-1:0]  character,
  input  wire logic                   char_valid,
  input  wire logic [RADIX_WIDTH-1:0] radix,
  input  wire logic                   last,
  output logic                        result_valid,
  input  wire logic                   result_ready,
  output logic [MAG_WIDTH-1:0]        magnitude,
  output logic                        negative,
  output logic                        not_a_number,
  output logic                        saturated
);

  localparam int PROD_W = VALUE_WIDTH + RADIX_WIDTH;
  localparam logic [VALUE_WIDTH-1:0] VALUE_MAX = {VALUE_WIDTH{1'b1}};

  // input register
  logic                   in_full;
  logic [CHAR_WIDTH-1:0]  in_char;
  logic                   in_cvalid;
  logic [RADIX_WIDTH-1:0] in_radix;
  logic                   in_last;

  // parse state
  phase_t                 phase, phase_next;
  logic                   sign_negative, sign_negative_next;
  logic [VALUE_WIDTH-1:0] accumulator, accumulator_next;
  logic                   overflowed, overflowed_next;
  logic [RADIX_WIDTH-1:0] radix_in_use, radix_in_use_next;
  logic                   prefix_allowed, prefix_allowed_next;
  logic                   leading_zero_seen, leading_zero_seen_next;
  logic                   digit_seen, digit_seen_next;

  logic                   proc_go;
  logic [RADIX_WIDTH-1:0] rad_s;
  logic [RADIX_WIDTH-1:0] dig;
  logic [PROD_W-1:0]      prod;
  logic                   prod_over;
  logic                   is_space;
  logic                   take_first;
  logic                   take_dig;
  logic                   res_nan;
  logic [MAG_WIDTH-1:0]   res_mag;
  logic                   res_neg;
  logic                   res_sat;

  assign proc_go    = in_full && (!in_last || !result_valid || result_ready);
  assign item_ready = !in_full || proc_go;

  // radix for the digit of this transaction, sampled at the start of a string
  assign rad_s     = (phase != PH_START) ? radix_in_use :
                     (in_radix == '0) ? RADIX_DEFAULT : in_radix;
  assign dig       = digit_value(in_char);
  assign is_space  = (in_char == CH_SPACE) || (in_char >= CH_TAB && in_char <= CH_CR);
  assign prod      = PROD_W'(accumulator) * PROD_W'(rad_s) + PROD_W'(dig);
  assign prod_over = prod[PROD_W-1:VALUE_WIDTH] != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (item_ready) begin
      in_full <= item_valid;
    end
    if (item_ready && item_valid) begin
      in_char   <= character;
      in_cvalid <= char_valid;
      in_radix  <= radix;
      in_last   <= last;
    end
  end

  // next state of the parse for the character in the input register
  always_comb begin
    phase_next             = phase;
    sign_negative_next     = sign_negative;
    accumulator_next       = accumulator;
    overflowed_next        = overflowed;
    radix_in_use_next      = radix_in_use;
    prefix_allowed_next    = prefix_allowed;
    leading_zero_seen_next = leading_zero_seen;
    digit_seen_next        = digit_seen;
    take_first             = 1'b0;
    take_dig               = 1'b0;

    // radix is sampled on the first transaction of a string
    if (phase == PH_START) begin
      if (in_radix == '0) begin
        radix_in_use_next   = RADIX_DEFAULT;
        prefix_allowed_next = 1'b1;
        phase_next          = PH_SPACE;
      end else if (in_radix < RADIX_MIN || in_radix > RADIX_MAX) begin
        phase_next = PH_BAD;
      end else begin
        radix_in_use_next   = in_radix;
        prefix_allowed_next = (in_radix == RADIX_HEX);
        phase_next          = PH_SPACE;
      end
    end

    if (in_cvalid) begin
      case (phase_next)
        PH_SPACE: begin
          if (is_space) begin
            phase_next = PH_SPACE;
          end else if (in_char == CH_MINUS) begin
            sign_negative_next = 1'b1;
            phase_next         = PH_FIRST;
          end else if (in_char == CH_PLUS) begin
            phase_next = PH_FIRST;
          end else begin
            take_first = 1'b1;
          end
        end
        PH_FIRST: begin
          take_first = 1'b1;
        end
        PH_ZERO: begin
          leading_zero_seen_next = 1'b0;
          phase_next             = PH_DIGITS;
          if (in_char == CH_LO_X || in_char == CH_UP_X) begin
            radix_in_use_next = RADIX_HEX;
          end else begin
            digit_seen_next = 1'b1;
            take_dig        = 1'b1;
          end
        end
        PH_DIGITS: begin
          take_dig = 1'b1;
        end
        default: begin
          take_dig = 1'b0;
        end
      endcase

      if (take_first) begin
        if (prefix_allowed_next && in_char == CH_ZERO) begin
          leading_zero_seen_next = 1'b1;
          phase_next             = PH_ZERO;
        end else begin
          phase_next = PH_DIGITS;
          take_dig   = 1'b1;
        end
      end

      if (take_dig) begin
        if (dig >= rad_s) begin
          phase_next = PH_STOPPED;
        end else begin
          digit_seen_next = 1'b1;
          if (prod_over) begin
            accumulator_next = VALUE_MAX;
            overflowed_next  = 1'b1;
          end else begin
            accumulator_next = prod[VALUE_WIDTH-1:0];
          end
        end
      end
    end
  end

  // result fields for a string that ends here
  always_comb begin
    res_nan = (phase_next == PH_BAD) || !(digit_seen_next || leading_zero_seen_next);
    res_mag = res_nan ? '0 : MAG_WIDTH'(accumulator_next);
    res_neg = !res_nan && sign_negative_next;
    res_sat = !res_nan && overflowed_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_START;
      sign_negative     <= 1'b0;
      accumulator       <= '0;
      overflowed        <= 1'b0;
      radix_in_use      <= RADIX_DEFAULT;
      prefix_allowed    <= 1'b1;
      leading_zero_seen <= 1'b0;
      digit_seen        <= 1'b0;
    end else if (proc_go) begin
      if (in_last) begin
        phase             <= PH_START;
        sign_negative     <= 1'b0;
        accumulator       <= '0;
        overflowed        <= 1'b0;
        radix_in_use      <= RADIX_DEFAULT;
        prefix_allowed    <= 1'b1;
        leading_zero_seen <= 1'b0;
        digit_seen        <= 1'b0;
      end else begin
        phase             <= phase_next;
        sign_negative     <= sign_negative_next;
        accumulator       <= accumulator_next;
        overflowed        <= overflowed_next;
        radix_in_use      <= radix_in_use_next;
        prefix_allowed    <= prefix_allowed_next;
        leading_zero_seen <= leading_zero_seen_next;
        digit_seen        <= digit_seen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (proc_go && in_last) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
    if (proc_go && in_last) begin
      magnitude    <= res_mag;
      negative     <= res_neg;
      not_a_number <= res_nan;
      saturated    <= res_sat;
    end
  end

`ifndef SYNTHESIS
  a_nan_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && not_a_number |-> magnitude == '0 && !negative && !saturated)
    else $error("not-a-number result carries a value");

  a_sat_max: assert property (@(posedge clk) disable iff (rst)
    result_valid && saturated |-> magnitude == MAG_WIDTH'(VALUE_MAX))
    else $error("saturated result is not the maximum");

  a_ovf_acc: assert property (@(posedge clk) disable iff (rst)
    overflowed |-> accumulator == VALUE_MAX)
    else $error("overflow flag without saturated accumulator");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    proc_go && in_last |=> phase == PH_START && accumulator == '0 && result_valid)
    else $error("state not cleared after end of string");
`endif

endmodule

`default_nettype wire

FILE: test/radix_integer_parser_tb.sv
// testbench for the radix integer parser: directed and random strings checked by a scoreboard
`timescale 1ns / 1ps

module radix_integer_parser_tb
  import rip_pkg::*;
;

  localparam int VW          = VALUE_WIDTH_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int ITEM_COUNT  = 800;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [MAG_WIDTH-1:0] mag;
    logic                 neg;
    logic                 nan;
    logic                 sat;
  } parse_result_t;

  // tracks the parse of the string in flight and the results still owed
  class parse_tracker;
    parse_result_t        pending_results[$];
    phase_t               ph;
    logic                 neg_sign;
    logic [MAG_WIDTH-1:0] acc;
    logic                 ovf;
    logic [5:0]           base;
    logic                 prefix_ok;
    logic                 zero_held;
    logic                 got_digit;
    logic [MAG_WIDTH-1:0] top_value;
    int                   errors;
    int                   strings;
    int                   chars;
    int                   nan_count;
    int                   sat_count;

    function new(int vw);
      top_value = {MAG_WIDTH{1'b1}} >> (MAG_WIDTH - vw);
      errors    = 0;
      strings   = 0;
      chars     = 0;
      nan_count = 0;
      sat_count = 0;
      clear();
    endfunction

    function void clear();
      ph        = PH_START;
      neg_sign  = 1'b0;
      acc       = '0;
      ovf       = 1'b0;
      base      = RADIX_DEFAULT;
      prefix_ok = 1'b1;
      zero_held = 1'b0;
      got_digit = 1'b0;
    endfunction

    function logic [5:0] digit_of(logic [7:0] c);
      logic [7:0] t;
      if (c >= CH_ZERO && c <= CH_NINE) begin
        t = c - CH_ZERO;
      end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
        t = c - CH_LO_A + 8'd10;
      end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
        t = c - CH_UP_A + 8'd10;
      end else begin
        t = {2'b00, NOT_DIGIT};
      end
      return t[5:0];
    endfunction

    function void add_digit(logic [7:0] c);
      logic [5:0]           d;
      logic [MAG_WIDTH-1:0] r;
      d = digit_of(c);
      if (d >= base) begin
        ph = PH_STOPPED;
        return;
      end
      got_digit = 1'b1;
      r = {58'd0, base};
      if (acc > (top_value - {58'd0, d}) / r) begin
        acc = top_value;
        ovf = 1'b1;
      end else begin
        acc = acc * r + {58'd0, d};
      end
    endfunction

    function void first_char(logic [7:0] c);
      if (prefix_ok && c == CH_ZERO) begin
        zero_held = 1'b1;
        ph        = PH_ZERO;
      end else begin
        ph = PH_DIGITS;
        add_digit(c);
      end
    endfunction

    function void take_item(logic [7:0] c, logic cv, logic [5:0] rq, logic lst);
      parse_result_t r;
      if (ph == PH_START) begin
        if (rq == '0) begin
          base      = RADIX_DEFAULT;
          prefix_ok = 1'b1;
          ph        = PH_SPACE;
        end else if (rq < RADIX_MIN || rq > RADIX_MAX) begin
          ph = PH_BAD;
        end else begin
          base      = rq;
          prefix_ok = (rq == RADIX_HEX);
          ph        = PH_SPACE;
        end
      end
      if (cv) begin
        chars++;
        case (ph)
          PH_SPACE: begin
            if (!(c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
              if (c == CH_MINUS) begin
                neg_sign = 1'b1;
                ph       = PH_FIRST;
              end else if (c == CH_PLUS) begin
                ph = PH_FIRST;
              end else begin
                first_char(c);
              end
            end
          end
          PH_FIRST: first_char(c);
          PH_ZERO: begin
            // a zero that could open a prefix: x switches to hex, anything else is a digit
            zero_held = 1'b0;
            ph        = PH_DIGITS;
            if (c == CH_LO_X || c == CH_UP_X) begin
              base = RADIX_HEX;
            end else begin
              got_digit = 1'b1;
              add_digit(c);
            end
          end
          PH_DIGITS: add_digit(c);
          default: ;
        endcase
      end
      if (!lst) return;
      if (zero_held) got_digit = 1'b1;
      r = '0;
      if (ph == PH_BAD || !got_digit) begin
        r.nan = 1'b1;
        nan_count++;
      end else begin
        r.mag = acc & top_value;
        r.neg = neg_sign;
        r.sat = ovf;
        if (ovf) sat_count++;
      end
      pending_results.push_back(r);
      strings++;
      clear();
    endfunction

    function void match_result(logic [MAG_WIDTH-1:0] m, logic n, logic nn, logic s);
      parse_result_t e;
      if (pending_results.size() == 0) begin
        $error("result with no string pending: magnitude %0d", m);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      if (m !== e.mag) begin
        $error("magnitude: expected %0d, got %0d", e.mag, m);
        errors++;
      end
      if (n !== e.neg) begin
        $error("negative: expected %0d, got %0d", e.neg, n);
        errors++;
      end
      if (nn !== e.nan) begin
        $error("not_a_number: expected %0d, got %0d", e.nan, nn);
        errors++;
      end
      if (s !== e.sat) begin
        $error("saturated: expected %0d, got %0d", e.sat, s);
        errors++;
      end
    endfunction
  endclass

  logic                   clk          = 1'b0;
  logic                   rst          = 1'b1;
  logic                   item_valid   = 1'b0;
  logic [CHAR_WIDTH-1:0]  character    = '0;
  logic                   char_valid   = 1'b0;
  logic [RADIX_WIDTH-1:0] radix        = '0;
  logic                   last         = 1'b0;
  logic                   result_ready = 1'b0;
  logic                   item_ready;
  logic                   result_valid;
  logic [MAG_WIDTH-1:0]   magnitude;
  logic                   negative;
  logic                   not_a_number;
  logic                   saturated;

  logic                   calm         = 1'b0;
  logic                   hold_req     = 1'b0;
  logic                   hold_done    = 1'b0;
  int                     hold_left    = 0;
  int                     cycles       = 0;
  int                     items_sent   = 0;
  logic [7:0]             text_q[$];

  parse_tracker sb = new(VW);

  radix_integer_parser #(.VALUE_WIDTH(VW)) uut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .character   (character),
    .char_valid  (char_valid),
    .radix       (radix),
    .last        (last),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .magnitude   (magnitude),
    .negative    (negative),
    .not_a_number(not_a_number),
    .saturated   (saturated)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off while the input backs up
  always @(posedge clk) begin
    if (hold_left != 0) begin
      result_ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      result_ready <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      hold_done    <= 1'b1;
    end else begin
      result_ready <= calm || ($urandom_range(99) >= 14);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && item_ready) sb.take_item(character, char_valid, radix, last);
      if (result_valid && result_ready)
        sb.match_result(magnitude, negative, not_a_number, saturated);
    end
  end

  task automatic send_item(input logic [7:0] c, input logic cv, input logic [5:0] rq,
                           input logic lst);
    if (!calm && $urandom_range(99) < 14) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    character  <= c;
    char_valid <= cv;
    radix      <= rq;
    last       <= lst;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    items_sent++;
  endtask

  // radix only matters on the first transaction of a string, so later ones carry noise
  task automatic send_text(input logic [5:0] rq, input bit tail_empty);
    int         i;
    logic [5:0] cur_rq;
    bit         first;
    first = 1'b1;
    for (i = 0; i < text_q.size(); i++) begin
      cur_rq = first ? rq : 6'($urandom_range(63));
      if (!calm && $urandom_range(99) < 8) begin
        send_item(8'($urandom_range(255)), 1'b0, cur_rq, 1'b0);
        first  = 1'b0;
        cur_rq = 6'($urandom_range(63));
      end
      send_item(text_q[i], 1'b1, cur_rq, (i == text_q.size() - 1) && !tail_empty);
      first = 1'b0;
    end
    if (tail_empty || text_q.size() == 0)
      send_item(8'($urandom_range(255)), 1'b0, first ? rq : 6'($urandom_range(63)), 1'b1);
  endtask

  task automatic load_text(input string s);
    int i;
    text_q.delete();
    for (i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  task automatic build_random_string(output logic [5:0] rq, output bit tail_empty);
    int         n;
    int         i;
    int         eff;
    logic [5:0] v;
    text_q.delete();
    tail_empty = ($urandom_range(99) < 15);
    if ($urandom_range(99) < 12) begin
      // pure noise: any bytes, any radix
      rq = 6'($urandom_range(63));
      n  = $urandom_range(0, 6);
      for (i = 0; i < n; i++) text_q.push_back(8'($urandom_range(255)));
      return;
    end
    case ($urandom_range(7))
      0:       rq = '0;
      1:       rq = RADIX_DEFAULT;
      2:       rq = RADIX_HEX;
      3:       rq = RADIX_MIN;
      4:       rq = RADIX_MAX;
      5:       rq = 6'd8;
      6:       rq = 6'($urandom_range(2, 32));
      default: rq = 6'($urandom_range(63));
    endcase
    eff = (rq == '0) ? 10 : int'(rq);
    repeat ($urandom_range(0, 2)) begin
      i = $urandom_range(0, 5);
      text_q.push_back((i == 5) ? CH_SPACE : CH_TAB + 8'(i));
    end
    case ($urandom_range(3))
      0:       text_q.push_back(CH_MINUS);
      1:       text_q.push_back(CH_PLUS);
      default: ;
    endcase
    if ((rq == '0 || rq == RADIX_HEX) && $urandom_range(99) < 40) begin
      text_q.push_back(CH_ZERO);
      text_q.push_back($urandom_range(1) ? CH_LO_X : CH_UP_X);
      eff = 16;
    end
    if (eff > 36) eff = 36;
    if (eff < 2) eff = 2;
    n = ($urandom_range(99) < 12) ? $urandom_range(10, 26) : $urandom_range(0, 8);
    for (i = 0; i < n; i++) begin
      // long strings lean on the top digit so they more often reach saturation
      v = (n >= 10 && $urandom_range(1) == 1) ? 6'(eff - 1) : 6'($urandom_range(eff - 1));
      if (v < 6'd10)
        text_q.push_back(CH_ZERO + {2'b00, v});
      else if ($urandom_range(1) == 1)
        text_q.push_back(CH_LO_A + {2'b00, v} - 8'd10);
      else
        text_q.push_back(CH_UP_A + {2'b00, v} - 8'd10);
    end
    if ($urandom_range(99) < 30) begin
      repeat ($urandom_range(1, 4)) text_q.push_back(8'($urandom_range(255)));
    end
  endtask

  initial begin
    logic [5:0] rq;
    bit         tail_empty;
    int         str_idx;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    load_text("\t-0X1f");
    send_text('0, 1'b0);
    load_text("0");
    send_text('0, 1'b0);
    load_text("09");
    send_text(6'd8, 1'b0);
    load_text("0x");
    send_text(RADIX_HEX, 1'b0);
    load_text("5");
    send_text(6'd1, 1'b0);
    text_q.delete();
    send_text(6'd33, 1'b1);
    load_text("+vV");
    text_q.push_back(8'hff);
    send_text(RADIX_MAX, 1'b1);
    load_text("vvvvvvvvvvvvv");
    send_text(RADIX_MAX, 1'b0);

    str_idx = 0;
    while (items_sent < ITEM_COUNT) begin
      if (str_idx == 10) hold_req <= 1'b1;
      calm <= (str_idx >= 30 && str_idx < 55);
      build_random_string(rq, tail_empty);
      send_text(rq, tail_empty);
      str_idx++;
    end
    item_valid <= 1'b0;
    calm       <= 1'b0;

    // wait for the results still owed to reach the scoreboard
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("tb: %0d strings, %0d characters, %0d transactions; %0d not a number, %0d saturated",
             sb.strings, sb.chars, items_sent, sb.nan_count, sb.sat_count);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
